>>> design/dcrm_pkg.sv
// Package for the duty cycle relay mode controller.
// Holds shared widths, codes, register reset values and the config/result structs.
// No dependencies.
package dcrm_pkg;

   localparam int CycleBits     = 22;
   localparam int DutyBits      = 7;
   localparam int DebounceBits  = 16;
   localparam int StepBits      = 10;
   localparam int PeriodDivBits = 16;
   localparam int OffPointBits  = DutyBits + PeriodDivBits;
   localparam int PosBits       = 2 * StepBits;
   localparam int CsrDataBits   = CycleBits;

   // Exact quotient by 100 for any 22-bit value: (x * RecipHundred) >> RecipShift
   localparam int RecipShift = CycleBits + 7;
   localparam logic [23:0] RecipHundred = 24'd5368710;
   localparam int RecipProdBits = CycleBits + 24;

   localparam logic [PosBits-1:0]  FrameSpan   = PosBits'(1000);
   localparam logic [3:0]          DutyToMs    = 4'd10;

   // Register reset values
   localparam logic [CycleBits-1:0]     PeriodReset    = CycleBits'(60000);
   localparam logic [PeriodDivBits-1:0] PeriodDivReset = PeriodDivBits'(600);
   localparam logic [DutyBits-1:0]      DutyReset      = DutyBits'(66);
   localparam logic [DebounceBits-1:0]  DebounceReset  = DebounceBits'(50);
   localparam logic [StepBits-1:0]      StepReset      = StepBits'(50);

   typedef enum logic [1:0] {
      CSR_PERIOD     = 2'd0,
      CSR_DUTY       = 2'd1,
      CSR_DEBOUNCE   = 2'd2,
      CSR_SHOW_STEP  = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_OFF  = 2'd0,
      MODE_ON   = 2'd1,
      MODE_DUTY = 2'd2
   } mode_type;

   typedef struct packed {
      logic [CycleBits-1:0]     period_ticks;
      logic [PeriodDivBits-1:0] period_div;
      logic [DutyBits-1:0]      duty_percent;
      logic [DebounceBits-1:0]  debounce_ticks;
      logic [StepBits-1:0]      show_step_ticks;
   } cfg_type;

   typedef struct packed {
      logic     relay_on;
      logic     green_led;
      mode_type mode_now;
      logic     press_seen;
   } result_type;

endpackage

>>> design/dcrm_if.sv
// Handshake channel interfaces for the request, response and register write ports.
// Depends on dcrm_pkg.
interface dcrm_req_if
   import dcrm_pkg::*;
   ();
   logic valid;
   logic ready;
   logic button_level;

   modport source (output valid, output button_level, input ready);
   modport sink   (input valid, input button_level, output ready);
endinterface

interface dcrm_rsp_if
   import dcrm_pkg::*;
   ();
   logic       valid;
   logic       ready;
   logic       relay_on;
   logic       green_led;
   logic [1:0] mode_now;
   logic       press_seen;

   modport source (output valid, output relay_on, output green_led, output mode_now,
                   output press_seen, input ready);
   modport sink   (input valid, input relay_on, input green_led, input mode_now,
                   input press_seen, output ready);
endinterface

interface dcrm_csr_if
   import dcrm_pkg::*;
   ();
   logic                   valid;
   logic                   ready;
   csr_index_type          index;
   logic [CsrDataBits-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/dcrm_csr_regs.sv
// Configuration registers of the mode controller, plus the period divided by 100.
// Depends on dcrm_pkg and dcrm_csr_if.
module dcrm_csr_regs
   import dcrm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   dcrm_csr_if.sink          csr_ch,
   output cfg_type           cfg
);

   cfg_type                  cfg_ff;
   logic [RecipProdBits-1:0] div_prod;
   logic                     wr_en;

   assign csr_ch.ready = 1'b1;
   assign wr_en        = csr_ch.valid;

   // Divide the written period by 100 with a reciprocal multiply
   assign div_prod = RecipProdBits'(csr_ch.data[CycleBits-1:0]) * RecipProdBits'(RecipHundred);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.period_ticks    <= PeriodReset;
         cfg_ff.period_div      <= PeriodDivReset;
         cfg_ff.duty_percent    <= DutyReset;
         cfg_ff.debounce_ticks  <= DebounceReset;
         cfg_ff.show_step_ticks <= StepReset;
      end else if (wr_en) begin
         unique case (csr_ch.index)
            CSR_PERIOD: begin
               cfg_ff.period_ticks <= csr_ch.data[CycleBits-1:0];
               cfg_ff.period_div   <= div_prod[RecipShift +: PeriodDivBits];
            end
            CSR_DUTY:      cfg_ff.duty_percent    <= csr_ch.data[DutyBits-1:0];
            CSR_DEBOUNCE:  cfg_ff.debounce_ticks  <= csr_ch.data[DebounceBits-1:0];
            CSR_SHOW_STEP: cfg_ff.show_step_ticks <= csr_ch.data[StepBits-1:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> design/dcrm_tick_engine.sv
// Per-tick state of the controller: debouncer, mode, indicator frame and duty cycle.
// Computes one result per stepped tick. Depends on dcrm_pkg.
module dcrm_tick_engine
   import dcrm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step_en,
   input  logic       level,
   input  cfg_type    cfg,
   output result_type result
);

   mode_type                  mode_ff, mode_in, mode_p;
   logic                      relay_ff, relay_in, relay_p;
   logic                      last_ff, last_in;
   logic                      stable_lvl_ff, stable_lvl_in;
   logic [DebounceBits-1:0]   stable_ff, stable_in;
   logic [CycleBits-1:0]      cycle_ff, cycle_in, cycle_p, cycle_inc;
   logic [StepBits-1:0]       sub_ff, sub_in, sub_inc;
   logic [StepBits-1:0]       frame_ff, frame_in;
   logic                      green_ff, green_in;
   logic                      accept, press, led_on;
   logic [PosBits-1:0]        pos;
   logic [PosBits-1:0]        duty_ms;
   logic [OffPointBits-1:0]   off_point;

   always_comb begin
      // Debounce: count stable ticks, accept the level once stable long enough
      if (level != last_ff) begin
         stable_in = '0;
      end else if (stable_ff != '1) begin
         stable_in = stable_ff + 1'b1;
      end else begin
         stable_in = stable_ff;
      end
      accept        = (stable_in > cfg.debounce_ticks) && (level != stable_lvl_ff);
      press         = accept && !level;
      stable_lvl_in = accept ? level : stable_lvl_ff;
      last_in       = level;

      // Step the mode on a press
      mode_p  = mode_ff;
      relay_p = relay_ff;
      cycle_p = cycle_ff;
      if (press) begin
         unique case (mode_ff)
            MODE_OFF: begin
               mode_p  = MODE_ON;
               relay_p = 1'b1;
            end
            MODE_ON: begin
               mode_p  = MODE_DUTY;
               relay_p = 1'b1;
               cycle_p = '0;
            end
            default: begin
               mode_p  = MODE_OFF;
               relay_p = 1'b0;
            end
         endcase
      end

      // Indicator frame
      sub_inc  = sub_ff + 1'b1;
      pos      = PosBits'(frame_ff) * PosBits'(cfg.show_step_ticks);
      duty_ms  = PosBits'(cfg.duty_percent) * PosBits'(DutyToMs);
      led_on   = ((mode_p == MODE_OFF) && (frame_ff == '0)) || (mode_p == MODE_ON) ||
                 ((mode_p == MODE_DUTY) && (pos < duty_ms));
      sub_in   = sub_inc;
      green_in = green_ff;
      frame_in = frame_ff;
      if (sub_inc >= cfg.show_step_ticks) begin
         sub_in   = '0;
         green_in = led_on;
         frame_in = (pos < FrameSpan) ? frame_ff + 1'b1 : '0;
      end

      // Duty cycle counter
      off_point = OffPointBits'(cfg.duty_percent) * OffPointBits'(cfg.period_div);
      cycle_inc = cycle_p + 1'b1;
      mode_in   = mode_p;
      relay_in  = relay_p;
      cycle_in  = cycle_p;
      if ((mode_p == MODE_DUTY) && !press) begin
         cycle_in = cycle_inc;
         if (cycle_inc >= cfg.period_ticks) begin
            cycle_in = '0;
            relay_in = 1'b1;
         end else if ((off_point != '0) && (OffPointBits'(cycle_inc) == off_point)) begin
            relay_in = 1'b0;
         end
      end

      result.relay_on   = relay_in;
      result.green_led  = green_in;
      result.mode_now   = mode_in;
      result.press_seen = press;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_OFF;
         relay_ff      <= 1'b0;
         last_ff       <= 1'b1;
         stable_lvl_ff <= 1'b0;
         stable_ff     <= '0;
         cycle_ff      <= '0;
         sub_ff        <= '0;
         frame_ff      <= '0;
         green_ff      <= 1'b0;
      end else if (step_en) begin
         mode_ff       <= mode_in;
         relay_ff      <= relay_in;
         last_ff       <= last_in;
         stable_lvl_ff <= stable_lvl_in;
         stable_ff     <= stable_in;
         cycle_ff      <= cycle_in;
         sub_ff        <= sub_in;
         frame_ff      <= frame_in;
         green_ff      <= green_in;
      end
   end

endmodule

>>> design/duty_cycle_relay_mode_controller_unit.sv
// Duty cycle relay mode controller, top level.
// A request passes through the input register and then the result register.
// Throughput: one request per cycle (single-pass tick engine) unless responses stall.
// Reset (synchronous, active high) empties both registers and returns all state and
// configuration registers to their defaults. Depends on dcrm_pkg and dcrm_if.
module duty_cycle_relay_mode_controller_unit
   import dcrm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   dcrm_req_if.sink   req_ch,
   dcrm_rsp_if.source rsp_ch,
   dcrm_csr_if.sink   csr_ch
);

   cfg_type    cfg;
   result_type result;
   logic       in_valid_ff;
   logic       in_level_ff;
   logic       out_valid_ff;
   result_type out_ff;
   logic       advance;

   dcrm_csr_regs u_csr_regs (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   dcrm_tick_engine u_tick_engine (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .level   (in_level_ff),
      .cfg     (cfg),
      .result  (result)
   );

   // Move the held request into the result register when it is free or drained
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_level_ff <= req_ch.button_level;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.relay_on   = out_ff.relay_on;
   assign rsp_ch.green_led  = out_ff.green_led;
   assign rsp_ch.mode_now   = out_ff.mode_now;
   assign rsp_ch.press_seen = out_ff.press_seen;

endmodule

>>> verif/tb.sv
// Testbench for duty_cycle_relay_mode_controller_unit: button tick requests in, checked results out.
// Runs directed and random button patterns under several register settings against a built-in predictor.
// Depends on dcrm_pkg, dcrm_if and the unit under test.
module tb
   import dcrm_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SettleCycles = 4;
   localparam int MaxGap       = 19;

   // Predictor of the relay mode controller plus the store of expected results
   class relay_mode_scoreboard;
      bit [CycleBits-1:0]    period;
      bit [DutyBits-1:0]     duty;
      bit [DebounceBits-1:0] debounce;
      bit [StepBits-1:0]     show_step;

      mode_type              mode;
      bit                    relay;
      bit                    green;
      bit                    last_level;
      bit                    stable_level;
      bit [DebounceBits-1:0] stable_count;
      bit [CycleBits-1:0]    cycle_count;
      bit [StepBits-1:0]     sub_count;
      bit [StepBits-1:0]     frame;

      result_type            expected_q[$];
      int unsigned           errors;
      int unsigned           ticks;
      int unsigned           checked;
      int unsigned           presses;

      function new();
         period       = PeriodReset;
         duty         = DutyReset;
         debounce     = DebounceReset;
         show_step    = StepReset;
         mode         = MODE_OFF;
         relay        = 1'b0;
         green        = 1'b0;
         last_level   = 1'b1;
         stable_level = 1'b0;
         stable_count = '0;
         cycle_count  = '0;
         sub_count    = '0;
         frame        = '0;
         errors       = 0;
         ticks        = 0;
         checked      = 0;
         presses      = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [CsrDataBits-1:0] value);
         case (idx)
            CSR_PERIOD:    period    = value[CycleBits-1:0];
            CSR_DUTY:      duty      = value[DutyBits-1:0];
            CSR_DEBOUNCE:  debounce  = value[DebounceBits-1:0];
            CSR_SHOW_STEP: show_step = value[StepBits-1:0];
            default: ;
         endcase
      endfunction

      // Advance the model by one accepted tick request and queue the expected result
      function void note_tick(bit level);
         bit          press;
         bit          lit;
         int unsigned pos;
         int unsigned off_point;
         result_type  exp_res;
         press = 1'b0;

         // debounce the raw level
         if (level != last_level) begin
            stable_count = '0;
         end else if (stable_count != '1) begin
            stable_count = stable_count + 1'b1;
         end
         if (stable_count > debounce && level != stable_level) begin
            stable_level = level;
            press = (level == 1'b0);
         end
         last_level = level;

         // step the mode on a press
         if (press) begin
            case (mode)
               MODE_OFF: begin
                  mode  = MODE_ON;
                  relay = 1'b1;
               end
               MODE_ON: begin
                  mode        = MODE_DUTY;
                  relay       = 1'b1;
                  cycle_count = '0;
               end
               default: begin
                  mode  = MODE_OFF;
                  relay = 1'b0;
               end
            endcase
         end

         // indicator frame
         sub_count = sub_count + 1'b1;
         if (sub_count >= show_step) begin
            pos = frame * show_step;
            lit = (mode == MODE_OFF && frame == 0) || mode == MODE_ON ||
                  (mode == MODE_DUTY && pos < duty * 10);
            sub_count = '0;
            green     = lit;
            frame     = (pos < 1000) ? frame + 1'b1 : '0;
         end

         // relay duty cycle, not counted on the press tick
         if (mode == MODE_DUTY && !press) begin
            off_point   = duty * (period / 100);
            cycle_count = cycle_count + 1'b1;
            if (cycle_count >= period) begin
               cycle_count = '0;
               relay       = 1'b1;
            end else if (off_point != 0 && cycle_count == off_point) begin
               relay = 1'b0;
            end
         end

         exp_res.relay_on   = relay;
         exp_res.green_led  = green;
         exp_res.mode_now   = mode;
         exp_res.press_seen = press;
         expected_q.push_back(exp_res);
         ticks++;
         if (press) presses++;
      endfunction

      // Compare one accepted result against the oldest expectation
      function void check_result(logic relay_on, logic green_led, logic [1:0] mode_now,
                                 logic press_seen);
         result_type exp_res;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result relay_on=%b green_led=%b mode_now=%0d press_seen=%b",
                     $time, relay_on, green_led, mode_now, press_seen);
            errors++;
            return;
         end
         exp_res = expected_q.pop_front();
         checked++;
         if (relay_on !== exp_res.relay_on) begin
            $display("%0t: relay_on expected %b actual %b", $time, exp_res.relay_on, relay_on);
            errors++;
         end
         if (green_led !== exp_res.green_led) begin
            $display("%0t: green_led expected %b actual %b", $time, exp_res.green_led, green_led);
            errors++;
         end
         if (mode_now !== exp_res.mode_now) begin
            $display("%0t: mode_now expected %0d actual %0d", $time, exp_res.mode_now, mode_now);
            errors++;
         end
         if (press_seen !== exp_res.press_seen) begin
            $display("%0t: press_seen expected %b actual %b", $time, exp_res.press_seen,
                     press_seen);
            errors++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   dcrm_req_if req_if();
   dcrm_rsp_if rsp_if();
   dcrm_csr_if csr_if();

   relay_mode_scoreboard sb = new();

   duty_cycle_relay_mode_controller_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset <= 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   // Give up on a hung run
   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // Wait until every expected result has come, then let the pipeline drain
   task automatic settle();
      do @(posedge clock); while (sb.pending() != 0);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // Write all four registers back to back, holding valid across the writes
   task automatic write_regs(logic [CsrDataBits-1:0] period, logic [CsrDataBits-1:0] duty,
                             logic [CsrDataBits-1:0] debounce, logic [CsrDataBits-1:0] step);
      csr_index_type          order[4];
      logic [CsrDataBits-1:0] value[4];
      order = '{CSR_PERIOD, CSR_DUTY, CSR_DEBOUNCE, CSR_SHOW_STEP};
      value = '{period, duty, debounce, step};
      for (int i = 0; i < 4; i++) begin
         csr_if.valid <= 1'b1;
         csr_if.index <= order[i];
         csr_if.data  <= value[i];
         do @(posedge clock); while (!csr_if.ready);
         sb.set_reg(order[i], value[i]);
      end
      csr_if.valid <= 1'b0;
   endtask

   // Send one tick request after an optional gap; hold drains all results first
   task automatic send_tick(bit level, int gap, bit hold);
      if (gap > 0 || hold) begin
         req_if.valid <= 1'b0;
         if (hold) settle();
         repeat (gap) @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.button_level <= level;
      do @(posedge clock); while (!req_if.ready);
      sb.note_tick(level);
   endtask

   // Drive button runs: with debounce below 100, mostly runs long enough to pass it, some bounce; else short runs
   task automatic drive_ticks(int count, int hold_at);
      int sent;
      int run_len;
      bit quiet;
      bit level;
      sent  = 0;
      quiet = 1'b0;
      level = 1'($urandom_range(0, 1));
      while (sent < count) begin
         if (sb.debounce < 100) begin
            if ($urandom_range(0, 4) != 0) run_len = sb.debounce + 2 + $urandom_range(0, 3);
            else run_len = $urandom_range(1, sb.debounce + 1);
         end else begin
            run_len = $urandom_range(1, 6);
         end
         for (int k = 0; k < run_len && sent < count; k++) begin
            if (sent % 32 == 0) quiet = ($urandom_range(0, 3) == 0);
            send_tick(level, quiet ? 0 : $urandom_range(0, MaxGap), sent == hold_at);
            sent++;
         end
         if ($urandom_range(0, 9) != 0) level = ~level;
      end
      req_if.valid <= 1'b0;
   endtask

   task automatic run_setting(int period, int duty, int debounce, int step, int count,
                              int hold_at);
      settle();
      write_regs(CsrDataBits'(period), CsrDataBits'(duty), CsrDataBits'(debounce),
                 CsrDataBits'(step));
      drive_ticks(count, hold_at);
   endtask

   // Accept results with random stalls and check them
   initial begin
      int stall;
      bit quiet;
      int taken;
      taken = 0;
      quiet = 1'b0;
      rsp_if.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (taken % 32 == 0) quiet = ($urandom_range(0, 3) == 0);
         stall = quiet ? 0 : $urandom_range(0, MaxGap);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         sb.check_result(rsp_if.relay_on, rsp_if.green_led, rsp_if.mode_now, rsp_if.press_seen);
         taken++;
      end
   end

   // Main sequence: directed presses, then random phases under several settings
   initial begin
      bit directed[24];
      int settings;
      directed = '{1, 1, 0, 0, 1, 1, 0, 0, 1, 1, 1, 1, 0, 1, 0, 0, 1, 0, 1, 0, 1, 1, 0, 0};
      settings = 0;
      req_if.valid        <= 1'b0;
      req_if.button_level <= 1'b1;
      csr_if.valid        <= 1'b0;
      csr_if.index        <= CSR_PERIOD;
      csr_if.data         <= '0;
      do @(posedge clock); while (reset);

      // walk through every mode with the shortest debounce and period
      write_regs(100, 1, 0, 1);
      settings++;
      foreach (directed[i]) send_tick(directed[i], $urandom_range(0, 2), 1'b0);
      req_if.valid <= 1'b0;

      run_setting(100, 99, 2, 1000, 70, -1);
      run_setting($urandom_range(100, 400), $urandom_range(1, 99), $urandom_range(0, 4),
                  $urandom_range(1, 20), 60, -1);
      run_setting(4194303, 1, 0, 1, 40, -1);
      run_setting($urandom_range(100, 400), $urandom_range(1, 99), $urandom_range(0, 4),
                  $urandom_range(1, 20), 60, -1);
      run_setting(60000, 66, 50, 50, 100, -1);
      run_setting($urandom_range(100, 300), $urandom_range(1, 99), 65535,
                  $urandom_range(1, 1000), 30, -1);
      run_setting($urandom_range(100, 200), $urandom_range(1, 99), $urandom_range(0, 3),
                  $urandom_range(1, 10), 70, 35);
      settings += 7;

      settle();
      if (sb.pending() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, sb.pending());
         sb.errors++;
      end
      $display("Checked %0d results for %0d button ticks (%0d presses) over %0d settings.",
               sb.checked, sb.ticks, sb.presses, settings);
      if (sb.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
